// ===== hdl/sws_pkg.sv =====
package sws_pkg;

  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_OK     = 3'd1;
  localparam logic [2:0] REQ_ERROR  = 3'd2;
  localparam logic [2:0] REQ_CANCEL = 3'd3;
  localparam logic [2:0] REQ_STOP   = 3'd4;
  localparam logic [2:0] REQ_END    = 3'd5;

  localparam logic [1:0] HDR_DATA = 2'd0;
  localparam logic [1:0] HDR_ERR  = 2'd1;
  localparam logic [1:0] HDR_CCL  = 2'd2;

  localparam logic [1:0] CFG_FILE_LENGTH     = 2'd0;
  localparam logic [1:0] CFG_SEGMENT_PAYLOAD = 2'd1;
  localparam logic [1:0] CFG_PACKET_COUNT    = 2'd2;

  localparam logic [15:0] RST_SEGMENT_PAYLOAD = 16'd1012;
  localparam logic [31:0] RST_PACKET_COUNT    = 32'd1;

  localparam logic [7:0] RETRY_LIMIT = 8'd10;
  localparam logic [7:0] RETRY_MAX   = 8'd255;

  localparam int PROD_W    = 39;
  localparam int DIV_STEPS = 39;
  localparam int CNT_W     = 6;
  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef struct packed {
    logic cap;
    logic mul;
    logic step;
    logic upd;
  } sws_cmd_t;

endpackage

// ===== hdl/sws_ctrl.sv =====
module sws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sws_pkg::sws_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [sws_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_free;
  logic                       last_step;

  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (cnt_r == sws_pkg::CNT_W'(sws_pkg::DIV_STEPS - 1));
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.upd       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_upd_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (!out_valid_r || out_ready))
    else $error("result overwrites a pending transaction");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < sws_pkg::CNT_W'(sws_pkg::DIV_STEPS)))
    else $error("divider step count out of range");

  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> ($past(state_r) == ST_DIV || $past(state_r) == ST_DONE))
    else $error("result produced without a division");
`endif

endmodule

// ===== hdl/sws_dpath.sv =====
module sws_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  sws_pkg::sws_cmd_t cmd,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        in_req_type,
  input  logic [31:0]       in_echo_start,
  input  logic [15:0]       in_echo_size,
  input  logic              in_pause_flag,
  input  logic              in_cancel_flag,
  output logic              out_send_valid,
  output logic [31:0]       out_seg_offset,
  output logic [15:0]       out_seg_length,
  output logic [1:0]        out_header_code,
  output logic              out_finished,
  output logic [6:0]        out_progress_pct,
  output logic [7:0]        out_retry_total
);

  logic [31:0] file_length_r;
  logic [15:0] segment_payload_r;
  logic [31:0] packet_count_r;

  logic [31:0] last_offset_r, last_offset_nxt;
  logic [15:0] last_length_r, last_length_nxt;
  logic [31:0] packet_index_r, packet_index_nxt;
  logic [7:0]  retry_count_r, retry_count_nxt;

  logic [2:0]  req_r;
  logic [31:0] es_r;
  logic [15:0] ez_r;
  logic        pause_r;
  logic        cancel_r;

  logic [32:0] nxt_r;
  logic [15:0] ok_len_r;

  logic [sws_pkg::PROD_W-1:0] dq_r;
  logic [31:0]                rem_r;
  logic [sws_pkg::PROD_W-1:0] prod;
  logic [32:0]                shifted;
  logic [33:0]                diff;
  logic                       ge;

  logic        send_valid_r;
  logic [31:0] seg_offset_r;
  logic [15:0] seg_length_r;
  logic [1:0]  header_code_r;
  logic        finished_r;
  logic [6:0]  progress_pct_r;
  logic [7:0]  retry_total_r;

  logic        send_nxt;
  logic [31:0] off_nxt;
  logic [15:0] len_nxt;
  logic [1:0]  hdr_nxt;
  logic        fin_nxt;
  logic [6:0]  pct;
  logic        match;
  logic [15:0] start_len;
  logic [31:0] ok_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r     <= '0;
      segment_payload_r <= sws_pkg::RST_SEGMENT_PAYLOAD;
      packet_count_r    <= sws_pkg::RST_PACKET_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sws_pkg::CFG_FILE_LENGTH:     file_length_r     <= cfg_data;
        sws_pkg::CFG_SEGMENT_PAYLOAD: segment_payload_r <= cfg_data[15:0];
        sws_pkg::CFG_PACKET_COUNT:    packet_count_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r    <= in_req_type;
      es_r     <= in_echo_start;
      ez_r     <= in_echo_size;
      pause_r  <= in_pause_flag;
      cancel_r <= in_cancel_flag;
    end
  end

  assign prod = sws_pkg::PROD_W'({packet_index_r, 6'b0})
              + sws_pkg::PROD_W'({packet_index_r, 5'b0})
              + sws_pkg::PROD_W'({packet_index_r, 2'b0});

  assign shifted = {rem_r, dq_r[sws_pkg::PROD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, packet_count_r};
  assign ge      = !diff[33];

  assign ok_rem = file_length_r - nxt_r[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dq_r  <= prod;
      rem_r <= '0;
      nxt_r <= {1'b0, es_r} + {17'b0, segment_payload_r};
    end else if (cmd.step) begin
      dq_r  <= {dq_r[sws_pkg::PROD_W-2:0], ge};
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      if (nxt_r < {1'b0, file_length_r}) begin
        ok_len_r <= (ok_rem < {16'b0, segment_payload_r}) ? ok_rem[15:0] : segment_payload_r;
      end else begin
        ok_len_r <= '0;
      end
    end
  end

  always_comb begin
    if (packet_count_r == '0) begin
      pct = '0;
    end else if (dq_r > sws_pkg::PROD_W'(sws_pkg::PCT_MAX)) begin
      pct = sws_pkg::PCT_MAX;
    end else begin
      pct = dq_r[6:0];
    end
  end

  assign match     = (es_r == last_offset_r) && (ez_r == last_length_r);
  assign start_len = (file_length_r <= {16'b0, segment_payload_r}) ?
                     file_length_r[15:0] : segment_payload_r;

  always_comb begin
    last_offset_nxt  = last_offset_r;
    last_length_nxt  = last_length_r;
    packet_index_nxt = packet_index_r;
    retry_count_nxt  = retry_count_r;
    send_nxt         = 1'b0;
    off_nxt          = '0;
    len_nxt          = '0;
    hdr_nxt          = sws_pkg::HDR_DATA;
    fin_nxt          = 1'b0;
    if (!pause_r) begin
      priority if (match && (req_r == sws_pkg::REQ_END || req_r == sws_pkg::REQ_CANCEL)) begin
        fin_nxt = 1'b1;
      end else if (match && req_r == sws_pkg::REQ_START && es_r == '0 && ez_r == '0) begin
        retry_count_nxt  = '0;
        packet_index_nxt = 32'd1;
        last_offset_nxt  = '0;
        last_length_nxt  = start_len;
        off_nxt          = '0;
        len_nxt          = start_len;
      end else if (match && req_r == sws_pkg::REQ_OK) begin
        retry_count_nxt  = '0;
        packet_index_nxt = packet_index_r + 32'd1;
        last_offset_nxt  = nxt_r[31:0];
        last_length_nxt  = ok_len_r;
        off_nxt          = nxt_r[31:0];
        len_nxt          = ok_len_r;
      end else if (match && req_r == sws_pkg::REQ_STOP) begin
        off_nxt = '0;
        len_nxt = '0;
      end else begin
        if (retry_count_r != sws_pkg::RETRY_MAX) begin
          retry_count_nxt = retry_count_r + 8'd1;
        end
        off_nxt = last_offset_r;
        len_nxt = last_length_r;
      end
      if (!fin_nxt) begin
        send_nxt = 1'b1;
        if (retry_count_nxt > sws_pkg::RETRY_LIMIT) begin
          hdr_nxt = sws_pkg::HDR_ERR;
        end
        if (cancel_r) begin
          hdr_nxt = sws_pkg::HDR_CCL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_offset_r  <= '0;
      last_length_r  <= '0;
      packet_index_r <= '0;
      retry_count_r  <= '0;
    end else if (cmd.upd) begin
      last_offset_r  <= last_offset_nxt;
      last_length_r  <= last_length_nxt;
      packet_index_r <= packet_index_nxt;
      retry_count_r  <= retry_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      send_valid_r   <= send_nxt;
      seg_offset_r   <= off_nxt;
      seg_length_r   <= len_nxt;
      header_code_r  <= hdr_nxt;
      finished_r     <= fin_nxt;
      progress_pct_r <= pct;
      retry_total_r  <= retry_count_nxt;
    end
  end

  assign out_send_valid   = send_valid_r;
  assign out_seg_offset   = seg_offset_r;
  assign out_seg_length   = seg_length_r;
  assign out_header_code  = header_code_r;
  assign out_finished     = finished_r;
  assign out_progress_pct = progress_pct_r;
  assign out_retry_total  = retry_total_r;

endmodule

// ===== hdl/stop_and_wait_segment_sender.sv =====
// A transaction runs through capture, the product step, the 39-step restoring
// divider for the progress percentage and the result update; a new one is
// accepted only after the previous one has handed over its result.
// The next transaction is accepted while a result still waits on out_ready.
// Reset (rst_n, synchronous, active low) clears the segment state, counters,
// handshake state and restores the configuration register defaults.
module stop_and_wait_segment_sender (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_echo_start,
  input  logic [15:0] in_echo_size,
  input  logic        in_pause_flag,
  input  logic        in_cancel_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_valid,
  output logic [31:0] out_seg_offset,
  output logic [15:0] out_seg_length,
  output logic [1:0]  out_header_code,
  output logic        out_finished,
  output logic [6:0]  out_progress_pct,
  output logic [7:0]  out_retry_total
);

  sws_pkg::sws_cmd_t cmd;

  sws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sws_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_echo_start    (in_echo_start),
    .in_echo_size     (in_echo_size),
    .in_pause_flag    (in_pause_flag),
    .in_cancel_flag   (in_cancel_flag),
    .out_send_valid   (out_send_valid),
    .out_seg_offset   (out_seg_offset),
    .out_seg_length   (out_seg_length),
    .out_header_code  (out_header_code),
    .out_finished     (out_finished),
    .out_progress_pct (out_progress_pct),
    .out_retry_total  (out_retry_total)
  );

endmodule

// ===== dv/stop_and_wait_segment_sender_tb.sv =====
`timescale 1ns / 1ps

module stop_and_wait_segment_sender_tb;

  localparam logic [2:0] REQ_OTHER = 3'd6;
  localparam logic [2:0] REQ_SPARE = 3'd7;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int LATENCY = 41;
  localparam int HOLD_CYCLES = 900;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTS = 20;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] echo_start;
    logic [15:0] echo_size;
    logic        pause;
    logic        cancel;
  } request_t;

  typedef struct packed {
    logic        send;
    logic [31:0] offset;
    logic [15:0] length;
    logic [1:0]  header;
    logic        finished;
    logic [6:0]  pct;
    logic [7:0]  retries;
  } segment_t;

  class segment_scoreboard;
    logic [31:0] file_length = '0;
    logic [15:0] seg_payload = sws_pkg::RST_SEGMENT_PAYLOAD;
    logic [31:0] pkt_count = sws_pkg::RST_PACKET_COUNT;
    logic [31:0] last_off = '0;
    logic [15:0] last_len = '0;
    logic [31:0] pkt_idx = '0;
    logic [7:0]  retries = '0;
    logic [6:0]  pct = '0;
    segment_t    segments_due[$];
    int errors = 0;
    int n_checked = 0;
    int n_finished = 0;
    int n_err_hdr = 0;
    int n_paused = 0;
    int retry_peak = 0;

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        sws_pkg::CFG_FILE_LENGTH:     file_length = data;
        sws_pkg::CFG_SEGMENT_PAYLOAD: seg_payload = data[15:0];
        sws_pkg::CFG_PACKET_COUNT:    pkt_count = data;
        default: ;
      endcase
    endfunction

    function void note_response(request_t r);
      segment_t    s;
      logic [63:0] ratio;
      logic [32:0] nxt;
      logic [32:0] rem;
      logic        match;
      logic        stop;
      s = '0;
      if (pkt_count == '0) begin
        pct = '0;
      end else begin
        ratio = ({32'd0, pkt_idx} * 64'd100) / {32'd0, pkt_count};
        pct = (ratio > 64'd100) ? sws_pkg::PCT_MAX : ratio[6:0];
      end
      if (r.pause) begin
        n_paused++;
      end else begin
        match = (r.echo_start == last_off) && (r.echo_size == last_len);
        stop = match && (r.kind == sws_pkg::REQ_STOP);
        if (match && (r.kind == sws_pkg::REQ_END || r.kind == sws_pkg::REQ_CANCEL)) begin
          s.finished = 1'b1;
          n_finished++;
        end else begin
          if (match && r.kind == sws_pkg::REQ_START &&
              r.echo_start == '0 && r.echo_size == '0) begin
            retries = '0;
            pkt_idx = 32'd1;
            last_off = '0;
            last_len = (file_length <= {16'd0, seg_payload}) ? file_length[15:0] : seg_payload;
          end else if (match && r.kind == sws_pkg::REQ_OK) begin
            nxt = {1'b0, r.echo_start} + {17'd0, seg_payload};
            rem = {1'b0, file_length} - nxt;
            retries = '0;
            pkt_idx = pkt_idx + 32'd1;
            last_off = nxt[31:0];
            if (nxt >= {1'b0, file_length}) last_len = '0;
            else if (rem < {17'd0, seg_payload}) last_len = rem[15:0];
            else last_len = seg_payload;
          end else if (!stop) begin
            if (retries != sws_pkg::RETRY_MAX) retries = retries + 8'd1;
          end
          s.send = 1'b1;
          if (!stop) begin
            s.offset = last_off;
            s.length = last_len;
          end
          s.header = sws_pkg::HDR_DATA;
          if (retries > sws_pkg::RETRY_LIMIT) s.header = sws_pkg::HDR_ERR;
          if (r.cancel) s.header = sws_pkg::HDR_CCL;
          if (s.header == sws_pkg::HDR_ERR) n_err_hdr++;
        end
      end
      s.pct = pct;
      s.retries = retries;
      if (int'(retries) > retry_peak) retry_peak = int'(retries);
      segments_due = {segments_due, s};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MAX_PRINTS)
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_segment(segment_t got);
      segment_t want;
      if (segments_due.size() == 0) begin
        report("segment with nothing pending, offset", got.offset, '0);
        return;
      end
      want = segments_due.pop_front();
      n_checked++;
      if (got.send !== want.send)
        report("send_valid", 32'(got.send), 32'(want.send));
      if (got.offset !== want.offset) report("seg_offset", got.offset, want.offset);
      if (got.length !== want.length)
        report("seg_length", 32'(got.length), 32'(want.length));
      if (got.header !== want.header)
        report("header_code", 32'(got.header), 32'(want.header));
      if (got.finished !== want.finished)
        report("finished", 32'(got.finished), 32'(want.finished));
      if (got.pct !== want.pct)
        report("progress_pct", 32'(got.pct), 32'(want.pct));
      if (got.retries !== want.retries)
        report("retry_total", 32'(got.retries), 32'(want.retries));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [31:0] in_echo_start;
  logic [15:0] in_echo_size;
  logic        in_pause_flag;
  logic        in_cancel_flag;
  logic        out_valid;
  logic        out_ready;
  logic        out_send_valid;
  logic [31:0] out_seg_offset;
  logic [15:0] out_seg_length;
  logic [1:0]  out_header_code;
  logic        out_finished;
  logic [6:0]  out_progress_pct;
  logic [7:0]  out_retry_total;

  segment_scoreboard sb;
  bit in_eager;
  bit out_eager;
  bit hold_off_req;
  int burst_left;
  int n_sent;
  int n_settings;
  int n_holds;
  int cycle_count;

  stop_and_wait_segment_sender i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_echo_start    (in_echo_start),
    .in_echo_size     (in_echo_size),
    .in_pause_flag    (in_pause_flag),
    .in_cancel_flag   (in_cancel_flag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_send_valid   (out_send_valid),
    .out_seg_offset   (out_seg_offset),
    .out_seg_length   (out_seg_length),
    .out_header_code  (out_header_code),
    .out_finished     (out_finished),
    .out_progress_pct (out_progress_pct),
    .out_retry_total  (out_retry_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic request_t response(logic [2:0] kind, logic [31:0] es, logic [15:0] ez,
                                        logic pause, logic cancel);
    request_t r;
    r.kind = kind;
    r.echo_start = es;
    r.echo_size = ez;
    r.pause = pause;
    r.cancel = cancel;
    return r;
  endfunction

  function automatic request_t echo_back(logic [2:0] kind, logic pause, logic cancel);
    return response(kind, sb.last_off, sb.last_len, pause, cancel);
  endfunction

  function automatic request_t random_response();
    request_t r;
    int roll;
    r = echo_back(sws_pkg::REQ_OK, $urandom_range(0, 99) < 3, $urandom_range(0, 99) < 5);
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      r.kind = ($urandom_range(0, 3) == 0) ? REQ_OTHER : sws_pkg::REQ_ERROR;
    end else if (roll < 45) begin
      r.kind = sws_pkg::REQ_OK;
    end else if (roll < 51) begin
      r.kind = sws_pkg::REQ_START;
      if ($urandom_range(0, 1) == 1) begin
        r.echo_start = '0;
        r.echo_size = '0;
      end
    end else if (roll < 57) begin
      r.kind = sws_pkg::REQ_ERROR;
    end else if (roll < 61) begin
      r.kind = ($urandom_range(0, 1) == 1) ? REQ_OTHER : REQ_SPARE;
    end else if (roll < 65) begin
      r.kind = sws_pkg::REQ_STOP;
    end else if (roll < 68) begin
      r.kind = sws_pkg::REQ_END;
    end else if (roll < 71) begin
      r.kind = sws_pkg::REQ_CANCEL;
    end else if (roll < 75) begin
      burst_left = $urandom_range(8, 16);
      r.kind = sws_pkg::REQ_ERROR;
    end else if (roll < 87) begin
      r = response(3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      r.kind = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) r.echo_start ^= 32'd1 << $urandom_range(0, 31);
      else r.echo_size ^= 16'd1 << $urandom_range(0, 15);
    end
    return r;
  endfunction

  function automatic request_t retry_storm_response();
    request_t r;
    int pick;
    r = echo_back(sws_pkg::REQ_ERROR, $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 10);
    pick = $urandom_range(0, 3);
    if (pick == 1) begin
      r.kind = REQ_OTHER;
    end else if (pick == 2) begin
      r.kind = REQ_SPARE;
    end else if (pick == 3) begin
      r.kind = 3'($urandom_range(0, 7));
      r.echo_size = ~sb.last_len;
    end
    return r;
  endfunction

  task automatic offer(input request_t r);
    int gap;
    gap = in_eager ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // hold the transaction until accepted
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_echo_start <= r.echo_start;
    in_echo_size <= r.echo_size;
    in_pause_flag <= r.pause;
    in_cancel_flag <= r.cancel;
    do @(posedge clk); while (!in_ready);
    sb.note_response(r);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.segments_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [31:0] flen, input logic [15:0] pay,
                              input logic [31:0] cnt, input bit poke_spare);
    put_reg(sws_pkg::CFG_FILE_LENGTH, flen);
    put_reg(sws_pkg::CFG_SEGMENT_PAYLOAD, {16'($urandom), pay});
    put_reg(sws_pkg::CFG_PACKET_COUNT, cnt);
    if (poke_spare) put_reg(CFG_SPARE, $urandom);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_setting(input logic [31:0] flen, input logic [15:0] pay,
                             input logic [31:0] cnt, input int n, input bit storm,
                             input bit poke_spare, input bit pressure);
    settle();
    program_regs(flen, pay, cnt, poke_spare);
    in_eager = pressure || ($urandom_range(0, 3) == 0);
    out_eager = !pressure && ($urandom_range(0, 3) == 0);
    if (pressure) hold_off_req = 1'b1;
    burst_left = 0;
    repeat (n) offer(storm ? retry_storm_response() : random_response());
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d segments still pending", cycle_count,
             sb.segments_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : receiver
    int stall;
    segment_t got;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        stall = HOLD_CYCLES;
        hold_off_req = 1'b0;
        n_holds++;
      end else begin
        stall = out_eager ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.send = out_send_valid;
      got.offset = out_seg_offset;
      got.length = out_seg_length;
      got.header = out_header_code;
      got.finished = out_finished;
      got.pct = out_progress_pct;
      got.retries = out_retry_total;
      sb.check_segment(got);
    end
  end

  initial begin
    sb = new();
    in_eager = 1'b0;
    out_eager = 1'b0;
    hold_off_req = 1'b0;
    burst_left = 0;
    n_sent = 0;
    n_settings = 0;
    n_holds = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= sws_pkg::CFG_FILE_LENGTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_req_type <= sws_pkg::REQ_START;
    in_echo_start <= '0;
    in_echo_size <= '0;
    in_pause_flag <= 1'b0;
    in_cancel_flag <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    program_regs(32'd2500, 16'd1000, 32'd4, 1'b1);
    offer(response(sws_pkg::REQ_START, '0, '0, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_OK, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_OK, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_OK, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_ERROR, 1'b0, 1'b0));
    offer(echo_back(REQ_OTHER, 1'b0, 1'b0));
    offer(echo_back(REQ_SPARE, 1'b0, 1'b1));
    offer(echo_back(sws_pkg::REQ_STOP, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_OK, 1'b1, 1'b0));
    offer(response(sws_pkg::REQ_OK, sb.last_off ^ 32'd1, sb.last_len, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_START, 1'b0, 1'b0));
    repeat (6) offer(echo_back(sws_pkg::REQ_ERROR, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_ERROR, 1'b0, 1'b1));
    offer(echo_back(sws_pkg::REQ_END, 1'b0, 1'b0));
    offer(echo_back(sws_pkg::REQ_CANCEL, 1'b0, 1'b0));
    offer(response(sws_pkg::REQ_END, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0));
    offer(response(sws_pkg::REQ_CANCEL, '0, '0, 1'b1, 1'b1));
    offer(echo_back(sws_pkg::REQ_OK, 1'b0, 1'b0));

    run_setting(32'd5000, 16'd1000, 32'd5, 120, 1'b0, 1'b1, 1'b0);
    run_setting(32'd0, 16'd1, 32'd0, 100, 1'b0, 1'b0, 1'b0);
    run_setting(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 100, 1'b0, 1'b0, 1'b0);
    run_setting($urandom, 16'($urandom_range(1, 65535)), 32'd1, 120, 1'b0, 1'b0, 1'b1);
    run_setting(32'($urandom_range(0, 20000)), 16'd0, 32'($urandom_range(1, 9)), 100,
                1'b0, 1'b0, 1'b0);
    run_setting(32'd3000, 16'd512, 32'd3, 265, 1'b1, 1'b0, 1'b0);
    run_setting(32'($urandom_range(0, 100000)), 16'($urandom_range(1, 2048)),
                32'($urandom_range(1, 64)), 150, 1'b0, 1'b1, 1'b0);
    run_setting($urandom, 16'($urandom), $urandom, 100, 1'b0, 1'b0, 1'b0);

    settle();
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d responses over %0d register settings, %0d segments compared",
             n_sent, n_settings, sb.n_checked);
    $display("%0d error headers, %0d finished, %0d paused, retry peak %0d, %0d long stalls",
             sb.n_err_hdr, sb.n_finished, sb.n_paused, sb.retry_peak, n_holds);
    if (sb.errors == 0 && sb.segments_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
